// ----- hw/rtl/hhlt_pkg.sv -----
// shared types and constants of the http header line tokenizer
package hhlt_pkg;

    localparam int PENDING_DEPTH = 16;
    localparam int PEND_IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PEND_CW = $clog2(PENDING_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_START,
        PH_NAME,
        PH_LEAD,
        PH_VALUE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NAME,
        KIND_VALUE,
        KIND_LINE_END,
        KIND_HDR_END
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NO_COLON,
        ST_WS_COLON,
        ST_BAD_CHAR,
        ST_WS_OVF
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        status_t     status;
        logic [15:0] length;
    } result_t;

    typedef struct packed {
        phase_t               phase;
        logic                 bad;
        logic                 prev_ws;
        logic                 ws_colon;
        logic [PEND_CW-1:0]   cnt;
        logic                 ovf;
    } pstate_t;

    typedef struct packed {
        pstate_t              nxt;
        logic                 emit;
        kind_t                kind;
        logic [7:0]           data;
        logic                 flush;
        logic [PEND_CW-1:0]   flush_n;
        logic                 push;
        logic [PEND_IW-1:0]   push_idx;
    } take_t;

    typedef struct packed {
        logic                 load;
        logic                 head_v;
        result_t              head;
        logic [PEND_CW-1:0]   flush_n;
        logic                 tail_v;
        kind_t                tail_kind;
        logic [7:0]           tail_byte;
        logic                 wr_a_en;
        logic [PEND_IW-1:0]   wr_a_idx;
        logic [7:0]           wr_a_byte;
        logic                 wr_b_en;
        logic [PEND_IW-1:0]   wr_b_idx;
        logic [7:0]           wr_b_byte;
    } job_t;

endpackage

// ----- hw/rtl/hhlt_in_if.sv -----
// input byte channel of the header tokenizer
interface hhlt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// ----- hw/rtl/hhlt_out_if.sv -----
// result channel of the header tokenizer
interface hhlt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [2:0]  line_status;
    logic [15:0] line_length;
    logic        last_of_run;

    modport source (output valid, output out_kind, output out_byte, output line_status,
                    output line_length, output last_of_run, input ready);
    modport sink (input valid, input out_kind, input out_byte, input line_status,
                  input line_length, input last_of_run, output ready);
endinterface

// ----- hw/rtl/hhlt_emit.sv -----
// result sequencer: whitespace buffer, job register and output register
module hhlt_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  hhlt_pkg::job_t    job,
    output logic              job_free,
    hhlt_out_if.source        out_ch
);

    logic [7:0]                    pend_mem [hhlt_pkg::PENDING_DEPTH];

    logic                          head_v_reg, head_v_next;
    hhlt_pkg::result_t             head_reg, head_next;
    logic [hhlt_pkg::PEND_CW-1:0]  fn_reg, fn_next;
    logic [hhlt_pkg::PEND_CW-1:0]  idx_reg, idx_next;
    logic                          tail_v_reg, tail_v_next;
    hhlt_pkg::kind_t               tail_kind_reg, tail_kind_next;
    logic [7:0]                    tail_byte_reg, tail_byte_next;

    logic                          out_v_reg, out_v_next;
    hhlt_pkg::result_t             out_res_reg, out_res_next;
    logic                          out_last_reg, out_last_next;

    logic                          flush_left;
    logic                          job_any;
    logic                          step;
    logic                          sel_last;
    hhlt_pkg::result_t             sel_res;

    assign flush_left = (idx_reg != fn_reg);
    assign job_any    = head_v_reg || flush_left || tail_v_reg;
    assign step       = job_any && (!out_v_reg || out_ch.ready);
    assign job_free   = !job_any || (step && sel_last);

    always_comb
    begin
        sel_res        = '0;
        sel_last       = 1'b1;
        head_v_next    = head_v_reg;
        head_next      = head_reg;
        fn_next        = fn_reg;
        idx_next       = idx_reg;
        tail_v_next    = tail_v_reg;
        tail_kind_next = tail_kind_reg;
        tail_byte_next = tail_byte_reg;

        if (head_v_reg)
        begin
            sel_res  = head_reg;
            sel_last = !flush_left && !tail_v_reg;
        end
        else if (flush_left)
        begin
            sel_res.kind = hhlt_pkg::KIND_VALUE;
            sel_res.data = pend_mem[idx_reg[hhlt_pkg::PEND_IW-1:0]];
            sel_last     = (idx_reg + 1'b1 == fn_reg) && !tail_v_reg;
        end
        else
        begin
            sel_res.kind = tail_kind_reg;
            sel_res.data = tail_byte_reg;
            sel_last     = 1'b1;
        end

        if (job.load)
        begin
            head_v_next    = job.head_v;
            head_next      = job.head;
            fn_next        = job.flush_n;
            idx_next       = '0;
            tail_v_next    = job.tail_v;
            tail_kind_next = job.tail_kind;
            tail_byte_next = job.tail_byte;
        end
        else if (step)
        begin
            if (head_v_reg)
            begin
                head_v_next = 1'b0;
            end
            else if (flush_left)
            begin
                idx_next = idx_reg + 1'b1;
            end
            else
            begin
                tail_v_next = 1'b0;
            end
        end

        out_v_next    = out_v_reg;
        out_res_next  = out_res_reg;
        out_last_next = out_last_reg;
        if (step)
        begin
            out_v_next    = 1'b1;
            out_res_next  = sel_res;
            out_last_next = sel_last;
        end
        else if (out_ch.ready)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_v_reg <= 1'b0;
            fn_reg     <= '0;
            idx_reg    <= '0;
            tail_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            head_v_reg <= head_v_next;
            fn_reg     <= fn_next;
            idx_reg    <= idx_next;
            tail_v_reg <= tail_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg      <= head_next;
        tail_kind_reg <= tail_kind_next;
        tail_byte_reg <= tail_byte_next;
        out_res_reg   <= out_res_next;
        out_last_reg  <= out_last_next;
        if (job.load && job.wr_a_en)
        begin
            pend_mem[job.wr_a_idx] <= job.wr_a_byte;
        end
        if (job.load && job.wr_b_en)
        begin
            pend_mem[job.wr_b_idx] <= job.wr_b_byte;
        end
    end

    assign out_ch.valid       = out_v_reg;
    assign out_ch.out_kind    = out_res_reg.kind;
    assign out_ch.out_byte    = out_res_reg.data;
    assign out_ch.line_status = out_res_reg.status;
    assign out_ch.line_length = out_res_reg.length;
    assign out_ch.last_of_run = out_last_reg;

endmodule

// ----- hw/rtl/http_header_line_tokenizer.sv -----
// top level of the http header line tokenizer
// Takes one header byte per cycle and emits one result per cycle through a
// registered output, while out_ch.ready is high. Most bytes give zero or one
// result, and the next byte is accepted in the following cycle unless the
// output stalls. A non-whitespace value byte releasing k held whitespace
// bytes gives k + 1 results (k up to 16) and holds input ready low until the
// output register has taken them all. A CR is held until the next byte shows
// whether it ends the line; a CR LF at line start ends the header block and
// the parser restarts. Line end results carry line status and byte length.
module http_header_line_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    hhlt_in_if.sink     in_ch,
    hhlt_out_if.source  out_ch
);

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    function automatic logic is_ws(logic [7:0] x);
        return (x == 8'h20) || (x >= 8'h09 && x <= 8'h0D);
    endfunction

    function automatic logic is_token(logic [7:0] x);
        logic r;
        r = (x >= 8'h41 && x <= 8'h5A) || (x >= 8'h61 && x <= 8'h7A) ||
            (x >= 8'h30 && x <= 8'h39);
        r = r || x == 8'h21 || x == 8'h23 || x == 8'h24 || x == 8'h25 ||
            x == 8'h26 || x == 8'h27 || x == 8'h2A || x == 8'h2B ||
            x == 8'h2D || x == 8'h2E || x == 8'h5E || x == 8'h5F ||
            x == 8'h60 || x == 8'h7C || x == 8'h7E;
        return r;
    endfunction

    function automatic logic [7:0] fold_case(logic [7:0] x);
        return (x >= 8'h41 && x <= 8'h5A) ? x + 8'h20 : x;
    endfunction

    function automatic hhlt_pkg::take_t take_byte(hhlt_pkg::pstate_t s, logic [7:0] x);
        hhlt_pkg::take_t t;
        t      = '0;
        t.nxt  = s;
        t.data = x;
        case (s.phase)
            hhlt_pkg::PH_START, hhlt_pkg::PH_NAME:
            begin
                if (x == CH_COLON)
                begin
                    t.nxt.ws_colon = s.prev_ws;
                    t.nxt.phase    = hhlt_pkg::PH_LEAD;
                end
                else
                begin
                    t.emit        = 1'b1;
                    t.kind        = hhlt_pkg::KIND_NAME;
                    t.data        = fold_case(x);
                    t.nxt.bad     = s.bad || !is_token(x);
                    t.nxt.prev_ws = is_ws(x);
                    t.nxt.phase   = hhlt_pkg::PH_NAME;
                end
            end
            hhlt_pkg::PH_LEAD:
            begin
                if (!is_ws(x))
                begin
                    t.emit      = 1'b1;
                    t.kind      = hhlt_pkg::KIND_VALUE;
                    t.nxt.phase = hhlt_pkg::PH_VALUE;
                end
            end
            hhlt_pkg::PH_VALUE:
            begin
                if (is_ws(x))
                begin
                    if (s.cnt < hhlt_pkg::PEND_CW'(hhlt_pkg::PENDING_DEPTH))
                    begin
                        t.push     = 1'b1;
                        t.push_idx = s.cnt[hhlt_pkg::PEND_IW-1:0];
                        t.nxt.cnt  = s.cnt + 1'b1;
                    end
                    else
                    begin
                        t.nxt.ovf = 1'b1;
                    end
                end
                else
                begin
                    t.emit    = 1'b1;
                    t.kind    = hhlt_pkg::KIND_VALUE;
                    t.flush   = 1'b1;
                    t.flush_n = s.cnt;
                    t.nxt.cnt = '0;
                end
            end
            default:
            begin
                t.nxt = s;
            end
        endcase
        return t;
    endfunction

    hhlt_pkg::pstate_t ps_reg, ps_next;
    logic              cr_held_reg, cr_held_next;
    logic [15:0]       bil_reg, bil_next;

    logic              accept;
    logic              job_free;
    logic [15:0]       bil_inc;
    logic [7:0]        b;
    hhlt_pkg::take_t   t_cr;
    hhlt_pkg::take_t   t_after_cr;
    hhlt_pkg::take_t   t_plain;
    hhlt_pkg::take_t   t_tail;
    hhlt_pkg::job_t    job;

    assign b            = in_ch.data_byte;
    assign in_ch.ready  = job_free;
    assign accept       = in_ch.valid && job_free;
    assign bil_inc      = (bil_reg != 16'hFFFF) ? bil_reg + 16'd1 : bil_reg;
    assign t_cr         = take_byte(ps_reg, CH_CR);
    assign t_after_cr   = take_byte(t_cr.nxt, b);
    assign t_plain      = take_byte(ps_reg, b);

    always_comb
    begin
        ps_next      = ps_reg;
        cr_held_next = cr_held_reg;
        bil_next     = bil_reg;
        job          = '0;
        job.load     = accept;
        t_tail       = '0;

        if (cr_held_reg)
        begin
            cr_held_next = 1'b0;
            if (b == CH_LF)
            begin
                job.head_v        = 1'b1;
                job.head.length   = bil_inc;
                if (ps_reg.phase == hhlt_pkg::PH_START)
                begin
                    job.head.kind = hhlt_pkg::KIND_HDR_END;
                end
                else
                begin
                    job.head.kind = hhlt_pkg::KIND_LINE_END;
                    if (ps_reg.phase == hhlt_pkg::PH_NAME)
                    begin
                        job.head.status = hhlt_pkg::ST_NO_COLON;
                    end
                    else if (ps_reg.ws_colon)
                    begin
                        job.head.status = hhlt_pkg::ST_WS_COLON;
                    end
                    else if (ps_reg.bad)
                    begin
                        job.head.status = hhlt_pkg::ST_BAD_CHAR;
                    end
                    else if (ps_reg.ovf)
                    begin
                        job.head.status = hhlt_pkg::ST_WS_OVF;
                    end
                    else
                    begin
                        job.head.status = hhlt_pkg::ST_OK;
                    end
                end
            end
            else
            begin
                // held cr is an ordinary byte: name byte, skipped leading whitespace or pending whitespace
                job.head_v      = t_cr.emit;
                job.head.kind   = t_cr.kind;
                job.head.data   = t_cr.data;
                job.wr_a_en     = t_cr.push;
                job.wr_a_idx    = t_cr.push_idx;
                job.wr_a_byte   = CH_CR;
                if (b == CH_CR)
                begin
                    cr_held_next = 1'b1;
                    t_tail       = '0;
                    t_tail.nxt   = t_cr.nxt;
                end
                else
                begin
                    t_tail = t_after_cr;
                end
            end
        end
        else if (b == CH_CR)
        begin
            cr_held_next = 1'b1;
            t_tail       = '0;
            t_tail.nxt   = ps_reg;
        end
        else
        begin
            t_tail = t_plain;
        end

        if (cr_held_reg && b == CH_LF)
        begin
            ps_next  = '0;
            bil_next = '0;
        end
        else
        begin
            ps_next  = t_tail.nxt;
            bil_next = bil_inc;
        end

        job.tail_v    = t_tail.emit;
        job.tail_kind = t_tail.kind;
        job.tail_byte = t_tail.data;
        job.flush_n   = t_tail.flush ? t_tail.flush_n : '0;
        job.wr_b_en   = t_tail.push;
        job.wr_b_idx  = t_tail.push_idx;
        job.wr_b_byte = b;

        if (!accept)
        begin
            ps_next      = ps_reg;
            cr_held_next = cr_held_reg;
            bil_next     = bil_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg      <= '0;
            cr_held_reg <= 1'b0;
            bil_reg     <= '0;
        end
        else
        begin
            ps_reg      <= ps_next;
            cr_held_reg <= cr_held_next;
            bil_reg     <= bil_next;
        end
    end

    hhlt_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job),
        .job_free (job_free),
        .out_ch   (out_ch)
    );

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench of the http header line tokenizer
`timescale 1ns / 1ps

module testbench;

    localparam logic [7:0] BYTE_CR = 8'h0d;
    localparam logic [7:0] BYTE_LF = 8'h0a;
    localparam logic [7:0] BYTE_COLON = 8'h3a;
    localparam logic [7:0] BYTE_SP = 8'h20;
    localparam logic [7:0] BYTE_HT = 8'h09;
    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_PERCENT = 38;

    typedef struct {
        hhlt_pkg::kind_t   kind;
        logic [7:0]        data;
        hhlt_pkg::status_t status;
        logic [15:0]       length;
        logic              last;
    } token_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    hhlt_in_if in_if ();
    hhlt_out_if out_if ();

    http_header_line_tokenizer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if)
    );

    always #4 clk = ~clk;

    // tokenizer state as seen from the stream
    hhlt_pkg::phase_t parse_phase = hhlt_pkg::PH_START;
    bit          cr_pending = 1'b0;
    bit          bad_name = 1'b0;
    bit          prev_name_ws = 1'b0;
    bit          ws_before_colon = 1'b0;
    logic [7:0]  held_ws [hhlt_pkg::PENDING_DEPTH];
    int          held_count = 0;
    bit          ws_overflow = 1'b0;
    int unsigned line_bytes = 0;

    token_beat_t expected_tokens [$];
    token_beat_t step_tokens [$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  bytes_sent = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  rx_hold_cycles = 0;

    function automatic bit is_space(input logic [7:0] b);
        return b == BYTE_SP || (b >= 8'h09 && b <= 8'h0d);
    endfunction

    function automatic bit is_tchar(input logic [7:0] b);
        if ((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) ||
            (b >= 8'h30 && b <= 8'h39))
            return 1'b1;
        case (b)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
            8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void emit_token(input hhlt_pkg::kind_t kind, input logic [7:0] data,
                                       input hhlt_pkg::status_t status,
                                       input logic [15:0] length);
        token_beat_t t;
        t.kind = kind;
        t.data = data;
        t.status = status;
        t.length = length;
        t.last = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void start_line();
        parse_phase = hhlt_pkg::PH_START;
        bad_name = 1'b0;
        prev_name_ws = 1'b0;
        ws_before_colon = 1'b0;
        held_count = 0;
        ws_overflow = 1'b0;
        line_bytes = 0;
    endfunction

    function automatic void parse_data_byte(input logic [7:0] b);
        logic [7:0] lc;
        case (parse_phase)
            hhlt_pkg::PH_START, hhlt_pkg::PH_NAME:
            begin
                if (b == BYTE_COLON)
                begin
                    ws_before_colon = prev_name_ws;
                    parse_phase = hhlt_pkg::PH_LEAD;
                end
                else
                begin
                    lc = (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
                    emit_token(hhlt_pkg::KIND_NAME, lc, hhlt_pkg::ST_OK, 16'd0);
                    if (!is_tchar(b))
                        bad_name = 1'b1;
                    prev_name_ws = is_space(b);
                    parse_phase = hhlt_pkg::PH_NAME;
                end
            end
            hhlt_pkg::PH_LEAD:
            begin
                if (!is_space(b))
                begin
                    emit_token(hhlt_pkg::KIND_VALUE, b, hhlt_pkg::ST_OK, 16'd0);
                    parse_phase = hhlt_pkg::PH_VALUE;
                end
            end
            default:
            begin
                if (is_space(b))
                begin
                    if (held_count < hhlt_pkg::PENDING_DEPTH)
                    begin
                        held_ws[held_count] = b;
                        held_count++;
                    end
                    else
                        ws_overflow = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < held_count; i++)
                        emit_token(hhlt_pkg::KIND_VALUE, held_ws[i], hhlt_pkg::ST_OK, 16'd0);
                    held_count = 0;
                    emit_token(hhlt_pkg::KIND_VALUE, b, hhlt_pkg::ST_OK, 16'd0);
                end
            end
        endcase
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        hhlt_pkg::status_t st;
        step_tokens.delete();
        if (line_bytes < 65535)
            line_bytes++;
        if (cr_pending)
        begin
            cr_pending = 1'b0;
            if (b == BYTE_LF)
            begin
                if (parse_phase == hhlt_pkg::PH_START)
                    emit_token(hhlt_pkg::KIND_HDR_END, 8'd0, hhlt_pkg::ST_OK, line_bytes[15:0]);
                else
                begin
                    if (parse_phase == hhlt_pkg::PH_NAME)
                        st = hhlt_pkg::ST_NO_COLON;
                    else if (ws_before_colon)
                        st = hhlt_pkg::ST_WS_COLON;
                    else if (bad_name)
                        st = hhlt_pkg::ST_BAD_CHAR;
                    else if (ws_overflow)
                        st = hhlt_pkg::ST_WS_OVF;
                    else
                        st = hhlt_pkg::ST_OK;
                    emit_token(hhlt_pkg::KIND_LINE_END, 8'd0, st, line_bytes[15:0]);
                end
                start_line();
            end
            else
            begin
                parse_data_byte(BYTE_CR);
                if (b == BYTE_CR)
                    cr_pending = 1'b1;
                else
                    parse_data_byte(b);
            end
        end
        else if (b == BYTE_CR)
            cr_pending = 1'b1;
        else
            parse_data_byte(b);
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endfunction

    // result side: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            rx_hold_cycles = rx_hold_cycles - 1;
            out_if.ready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(99) < IDLE_PERCENT)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected result: out_kind %0d out_byte 0x%02h", out_if.out_kind,
                       out_if.out_byte);
                error_count++;
            end
            else
            begin
                token_beat_t e;
                e = expected_tokens.pop_front();
                if (out_if.out_kind !== e.kind)
                begin
                    $error("out_kind expected %0d got %0d", e.kind, out_if.out_kind);
                    error_count++;
                end
                if (out_if.out_byte !== e.data)
                begin
                    $error("out_byte expected 0x%02h got 0x%02h", e.data, out_if.out_byte);
                    error_count++;
                end
                if (out_if.line_status !== e.status)
                begin
                    $error("line_status expected %0d got %0d", e.status, out_if.line_status);
                    error_count++;
                end
                if (out_if.line_length !== e.length)
                begin
                    $error("line_length expected %0d got %0d", e.length, out_if.line_length);
                    error_count++;
                end
                if (out_if.last_of_run !== e.last)
                begin
                    $error("last_of_run expected %0d got %0d", e.last, out_if.last_of_run);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (tx_idle_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data_byte <= b;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        predict_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_crlf();
        send_byte(BYTE_CR);
        send_byte(BYTE_LF);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(negedge clk);
        while (expected_tokens.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] rand_tchar();
        case ($urandom_range(3))
            0: return 8'h61 + 8'($urandom_range(25));
            1: return 8'h41 + 8'($urandom_range(25));
            2: return 8'h30 + 8'($urandom_range(9));
            default:
            begin
                case ($urandom_range(14))
                    0: return 8'h21;
                    1: return 8'h23;
                    2: return 8'h24;
                    3: return 8'h25;
                    4: return 8'h26;
                    5: return 8'h27;
                    6: return 8'h2a;
                    7: return 8'h2b;
                    8: return 8'h2d;
                    9: return 8'h2e;
                    10: return 8'h5e;
                    11: return 8'h5f;
                    12: return 8'h60;
                    13: return 8'h7c;
                    default: return 8'h7e;
                endcase
            end
        endcase
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(5))
            0: return BYTE_HT;
            1: return 8'h0b;
            2: return 8'h0c;
            3: return BYTE_LF;
            default: return BYTE_SP;
        endcase
    endfunction

    function automatic logic [7:0] rand_value_byte();
        if ($urandom_range(99) < 85)
            return 8'($urandom_range(8'h21, 8'h7e));
        return 8'($urandom_range(8'h80, 8'hff));
    endfunction

    task automatic send_random_line();
        bit clean;
        int name_len;
        int words;
        int run;
        clean = $urandom_range(99) < 70;
        name_len = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 8);
        for (int i = 0; i < name_len; i++)
        begin
            if (clean || $urandom_range(99) < 75)
                send_byte(rand_tchar());
            else
            begin
                case ($urandom_range(2))
                    0: send_byte(rand_space());
                    1: send_byte(BYTE_NUL);
                    default: send_byte(8'($urandom_range(255)));
                endcase
            end
        end
        if (clean || $urandom_range(99) < 80)
            send_byte(BYTE_COLON);
        run = $urandom_range(2);
        for (int i = 0; i < run; i++)
            send_byte(rand_space());
        words = $urandom_range(5);
        for (int w = 0; w < words; w++)
        begin
            run = $urandom_range(1, 6);
            for (int i = 0; i < run; i++)
                send_byte(rand_value_byte());
            run = ($urandom_range(99) < 10) ? $urandom_range(14, 20) : $urandom_range(1, 3);
            if (w == words - 1 && $urandom_range(99) < 70)
                run = 0;
            for (int i = 0; i < run; i++)
                send_byte(rand_space());
        end
        if ($urandom_range(99) < 4)
            send_byte(BYTE_CR);
        else
            send_crlf();
    endtask

    task automatic random_blocks(input int target);
        int start;
        int n;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            n = $urandom_range(99);
            if (n < 8)
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom_range(255)));
            end
            else if (n < 16)
                send_crlf();
            else
                send_random_line();
        end
    endtask

    task automatic test_header_end();
        send_crlf();
        send_text("Host:x");
        send_crlf();
        send_crlf();
    endtask

    task automatic test_empty_name();
        send_text(":v");
        send_crlf();
    endtask

    task automatic test_status_priority();
        send_byte(8'h41);
        send_byte(BYTE_NUL);
        send_byte(BYTE_SP);
        send_text(":x");
        send_crlf();
        send_byte(8'h42);
        send_byte(BYTE_NUL);
        send_text(":x");
        send_crlf();
        send_text("n ");
        send_crlf();
    endtask

    task automatic test_lone_cr_bare_lf();
        send_text("c:");
        send_byte(BYTE_CR);
        send_byte(8'h61);
        send_byte(BYTE_LF);
        send_byte(8'h62);
        send_byte(BYTE_CR);
        send_crlf();
        send_byte(8'h52);
        send_byte(BYTE_CR);
        send_text("s:v");
        send_crlf();
    endtask

    task automatic test_ws_overflow();
        send_text("k:v");
        for (int i = 0; i < 18; i++)
            send_byte(i[0] ? BYTE_HT : BYTE_SP);
        send_byte(8'h77);
        send_crlf();
    endtask

    task automatic test_byte_extremes();
        send_byte(8'hff);
        send_byte(8'h5a);
        send_byte(BYTE_COLON);
        send_byte(8'hff);
        send_byte(BYTE_NUL);
        send_byte(8'h7f);
        send_crlf();
        send_crlf();
    endtask

    task automatic test_output_stall();
        tx_idle_on = 1'b0;
        rx_hold_cycles = 300;
        send_text("X-Long:a");
        for (int w = 0; w < 8; w++)
        begin
            for (int i = 0; i < 12; i++)
                send_byte(BYTE_SP);
            send_text("word");
        end
        send_crlf();
        tx_idle_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        random_blocks(60);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        random_blocks(100);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        random_blocks(70);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data_byte = 8'd0;
        out_if.ready = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_header_end();
        test_empty_name();
        test_status_priority();
        test_lone_cr_bare_lf();
        test_ws_overflow();
        test_byte_extremes();
        wait_drained();
        test_output_stall();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_tokens.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
